>>> sv/sbeq_pkg.sv
// Shared constants for the stereo biquad equaliser cascade.
// Mode codes, coefficient slot order and default sizes; no dependencies.
package sbeq_pkg;

    localparam int NUM_BANDS_DEF   = 10;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEFF_BITS_DEF  = 32;

    // coefficients held per band
    localparam logic [2:0] NUM_COEFS = 3'd5;

    // input beat modes
    localparam logic [1:0] MODE_PROC  = 2'd0;
    localparam logic [1:0] MODE_COEF  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // slot of each coefficient within a band row
    localparam int SEL_B0 = 0;
    localparam int SEL_B1 = 1;
    localparam int SEL_B2 = 2;
    localparam int SEL_A1 = 3;
    localparam int SEL_A2 = 4;

endpackage

>>> sv/stereo_biquad_eq_cascade_core.sv
// Stereo biquad equaliser cascade: coefficient and history memories, sequencer
// and two multiply lanes (left, right). Depends on sbeq_pkg.
//
// A filtered sample pair is taken through every band before the block is ready
// again: each band row of coefficients and history is read once, and each channel's
// single multiplier is used five times per section (b0*x, b1*x, a1*y, b2*x, a2*y)
// before the new history row is written back. The read of the next band's row
// overlaps the write-back. A pass-through pair (enable low) goes straight to the
// output state; coefficient writes and history clears leave the block ready.
// History clear is immediate through per-band valid bits. Coefficients read before
// being written give undefined output. The finished pair sits in an output
// register, so the next beat can be taken while it waits downstream.
module stereo_biquad_eq_cascade_core #(
    parameter int NUM_BANDS_P = sbeq_pkg::NUM_BANDS_DEF,
    parameter int SAMPLE_BITS = sbeq_pkg::SAMPLE_BITS_DEF,
    parameter int COEFF_BITS  = sbeq_pkg::COEFF_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    input  logic                          i_block_end,
    input  logic [3:0]                    i_band_index,
    input  logic [2:0]                    i_coeff_select,
    input  logic signed [COEFF_BITS-1:0]  i_coeff_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out,
    output logic                          o_block_end_out
);

    localparam int HIST_BITS  = SAMPLE_BITS + 16;
    localparam int COEF_FRAC  = COEFF_BITS - 4;
    localparam int HIST_SHIFT = COEF_FRAC - 8;
    localparam int PROD_W     = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W      = SAMPLE_BITS + COEFF_BITS + 6;
    localparam int BAND_W     = (NUM_BANDS_P > 1) ? $clog2(NUM_BANDS_P) : 1;
    localparam int CROW_W     = int'(sbeq_pkg::NUM_COEFS) * COEFF_BITS;
    localparam int HROW_W     = 4 * HIST_BITS;

    localparam logic signed [ACC_W-1:0] SMP_MAX =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SMP_MIN =
        {{(ACC_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HIS_MAX =
        {{(ACC_W-HIST_BITS+1){1'b0}}, {(HIST_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] HIS_MIN =
        {{(ACC_W-HIST_BITS+1){1'b1}}, {(HIST_BITS-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_W-1:0] RND_H = ACC_W'(1) <<< (HIST_SHIFT - 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_RD   = 9'b000000010,
        S_M0   = 9'b000000100,
        S_Y    = 9'b000001000,
        S_M2   = 9'b000010000,
        S_M3   = 9'b000100000,
        S_M4   = 9'b001000000,
        S_WB   = 9'b010000000,
        S_OUT  = 9'b100000000
    } t_state;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > SMP_MAX) c = SMP_MAX;
        if (v < SMP_MIN) c = SMP_MIN;
        return c[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic signed [HIST_BITS-1:0] sat_his(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] c;
        c = v;
        if (v > HIS_MAX) c = HIS_MAX;
        if (v < HIS_MIN) c = HIS_MIN;
        return c[HIST_BITS-1:0];
    endfunction

    // control
    t_state                  r_state;
    logic [BAND_W-1:0]       r_band;
    logic                    r_enable;
    logic [NUM_BANDS_P-1:0]  r_hist_vld;
    logic                    r_out_valid;

    // datapath
    logic                          r_blk;
    logic signed [SAMPLE_BITS-1:0] r_x    [2];
    logic signed [SAMPLE_BITS-1:0] r_y    [2];
    logic signed [PROD_W-1:0]      r_prod [2];
    logic signed [ACC_W-1:0]       r_t1   [2];
    logic signed [ACC_W-1:0]       r_t2   [2];
    logic signed [SAMPLE_BITS-1:0] r_out_left;
    logic signed [SAMPLE_BITS-1:0] r_out_right;
    logic                          r_out_blk;

    // memories and their read registers
    logic [CROW_W-1:0] r_coef_mem [NUM_BANDS_P];
    logic [HROW_W-1:0] r_hist_mem [NUM_BANDS_P];
    logic [CROW_W-1:0] r_coef_rd;
    logic [HROW_W-1:0] r_hist_rd;
    logic              r_hist_rd_ok;

    logic                          accept;
    logic                          last_band;
    logic                          rd_en;
    logic [BAND_W-1:0]             rd_addr;
    logic                          coef_wr;
    logic                          out_free;
    logic                          mul_state;
    logic                          mul_use_y;
    logic signed [COEFF_BITS-1:0]  mul_coef;
    logic [HROW_W-1:0]             hist_row;
    logic [HROW_W-1:0]             hist_wr;
    logic signed [SAMPLE_BITS-1:0] mul_d   [2];
    logic signed [PROD_W-1:0]      prod_n  [2];
    logic signed [HIST_BITS-1:0]   s1      [2];
    logic signed [HIST_BITS-1:0]   s2      [2];
    logic signed [SAMPLE_BITS-1:0] y_n     [2];
    logic signed [ACC_W-1:0]       t1_pre  [2];
    logic signed [ACC_W-1:0]       t2_fin  [2];
    logic signed [HIST_BITS-1:0]   s1_n    [2];
    logic signed [HIST_BITS-1:0]   s2_n    [2];

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign last_band = (r_band == BAND_W'(NUM_BANDS_P - 1));
    assign out_free  = !r_out_valid || i_ready;
    assign rd_en     = (r_state == S_RD) || ((r_state == S_WB) && !last_band);
    assign rd_addr   = (r_state == S_WB) ? BAND_W'(r_band + BAND_W'(1)) : r_band;
    assign coef_wr   = accept && (i_mode == sbeq_pkg::MODE_COEF)
                       && ({1'b0, i_band_index} < 5'(NUM_BANDS_P))
                       && (i_coeff_select < sbeq_pkg::NUM_COEFS);

    assign mul_state = (r_state == S_M0) || (r_state == S_Y) || (r_state == S_M2)
                       || (r_state == S_M3) || (r_state == S_M4);
    assign mul_use_y = (r_state == S_M2) || (r_state == S_M4);
    assign hist_row  = r_hist_rd_ok ? r_hist_rd : '0;

    always_comb begin
        unique case (r_state)
            S_Y:     mul_coef = r_coef_rd[sbeq_pkg::SEL_B1*COEFF_BITS +: COEFF_BITS];
            S_M2:    mul_coef = r_coef_rd[sbeq_pkg::SEL_A1*COEFF_BITS +: COEFF_BITS];
            S_M3:    mul_coef = r_coef_rd[sbeq_pkg::SEL_B2*COEFF_BITS +: COEFF_BITS];
            S_M4:    mul_coef = r_coef_rd[sbeq_pkg::SEL_A2*COEFF_BITS +: COEFF_BITS];
            default: mul_coef = r_coef_rd[sbeq_pkg::SEL_B0*COEFF_BITS +: COEFF_BITS];
        endcase
    end

    // one lane per channel, history words ordered s1, s2 within each channel
    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            mul_d[ch]  = mul_use_y ? r_y[ch] : r_x[ch];
            prod_n[ch] = mul_coef * mul_d[ch];
            s1[ch]     = hist_row[(2*ch)*HIST_BITS +: HIST_BITS];
            s2[ch]     = hist_row[(2*ch+1)*HIST_BITS +: HIST_BITS];
            y_n[ch]    = sat_smp((ACC_W'(r_prod[ch]) + (ACC_W'(s1[ch]) <<< HIST_SHIFT)
                                  + RND_Y) >>> COEF_FRAC);
            t1_pre[ch] = ACC_W'(r_prod[ch]) + (ACC_W'(s2[ch]) <<< HIST_SHIFT);
            t2_fin[ch] = r_t2[ch] - ACC_W'(r_prod[ch]);
            s1_n[ch]   = sat_his((r_t1[ch] + RND_H) >>> HIST_SHIFT);
            s2_n[ch]   = sat_his((t2_fin[ch] + RND_H) >>> HIST_SHIFT);
        end
        hist_wr = {s2_n[1], s1_n[1], s2_n[0], s1_n[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_band      <= '0;
            r_enable    <= 1'b1;
            r_hist_vld  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_enable <= i_cfg_wdata;
            end
            if ((r_state == S_OUT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_mode == sbeq_pkg::MODE_PROC)) begin
                        r_band  <= '0;
                        r_state <= r_enable ? S_RD : S_OUT;
                    end
                    if (accept && (i_mode == sbeq_pkg::MODE_CLEAR)) begin
                        r_hist_vld <= '0;
                    end
                end
                S_RD: r_state <= S_M0;
                S_M0: r_state <= S_Y;
                S_Y:  r_state <= S_M2;
                S_M2: r_state <= S_M3;
                S_M3: r_state <= S_M4;
                S_M4: r_state <= S_WB;
                S_WB: begin
                    r_hist_vld[r_band] <= 1'b1;
                    if (last_band) begin
                        r_state <= S_OUT;
                    end else begin
                        r_band  <= BAND_W'(r_band + BAND_W'(1));
                        r_state <= S_M0;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x[0] <= i_left_in;
            r_x[1] <= i_right_in;
            r_blk  <= i_block_end;
        end
        for (int ch = 0; ch < 2; ch++) begin
            if (mul_state) begin
                r_prod[ch] <= prod_n[ch];
            end
            if (r_state == S_Y) begin
                r_y[ch] <= y_n[ch];
            end
            if (r_state == S_M2) begin
                r_t1[ch] <= t1_pre[ch];
            end
            if (r_state == S_M3) begin
                r_t1[ch] <= r_t1[ch] - ACC_W'(r_prod[ch]);
            end
            if (r_state == S_M4) begin
                r_t2[ch] <= ACC_W'(r_prod[ch]);
            end
            // section output feeds the next band
            if (r_state == S_WB) begin
                r_x[ch] <= r_y[ch];
            end
        end
        if ((r_state == S_OUT) && out_free) begin
            r_out_left  <= r_x[0];
            r_out_right <= r_x[1];
            r_out_blk   <= r_blk;
        end
    end

    // coefficient store, one row of five words per band
    always_ff @(posedge i_clk) begin
        if (coef_wr) begin
            r_coef_mem[i_band_index[BAND_W-1:0]]
                [int'(i_coeff_select)*COEFF_BITS +: COEFF_BITS] <= i_coeff_value;
        end
        if (rd_en) begin
            r_coef_rd <= r_coef_mem[rd_addr];
        end
    end

    // history store, one row of both channels' s1 and s2 per band
    always_ff @(posedge i_clk) begin
        if (r_state == S_WB) begin
            r_hist_mem[r_band] <= hist_wr;
        end
        if (rd_en) begin
            r_hist_rd    <= r_hist_mem[rd_addr];
            r_hist_rd_ok <= r_hist_vld[rd_addr];
        end
    end

    assign o_valid         = r_out_valid;
    assign o_left_out      = r_out_left;
    assign o_right_out     = r_out_right;
    assign o_block_end_out = r_out_blk;

    a_clear_drops_history: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == sbeq_pkg::MODE_CLEAR)) |=> (r_hist_vld == '0)
    ) else $error("history still marked valid after a clear beat");

    a_result_from_out_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_OUT)
    ) else $error("result loaded outside the output state");

    a_band_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_band <= BAND_W'(NUM_BANDS_P - 1))
    ) else $error("band counter beyond the last band");

    a_config_beat_no_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode != sbeq_pkg::MODE_PROC)) |=> (r_state == S_IDLE)
    ) else $error("non-sample beat started the cascade");

endmodule

>>> bench/tb.sv
// Self-checking bench for stereo_biquad_eq_cascade_core: a directed table, then
// random beats, checked against an in-bench fixed-point model of the band cascade.
// Depends on sbeq_pkg and the core RTL only.
module tb;

    localparam int NB          = sbeq_pkg::NUM_BANDS_DEF;
    localparam int SW          = sbeq_pkg::SAMPLE_BITS_DEF;
    localparam int CW          = sbeq_pkg::COEFF_BITS_DEF;
    localparam int HW          = SW + 16;
    localparam int COEF_FRAC   = CW - 4;
    localparam int HIST_SHIFT  = COEF_FRAC - 8;
    localparam int SETTLE      = 6 * NB + 3 + 20;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [1:0] MODE_SPARE      = 2'd3;
    localparam logic [2:0] SEL_SPARE_FIRST = 3'd5;
    localparam logic [2:0] SEL_SPARE_LAST  = 3'd7;

    localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam longint UNITY_Q = longint'(1) <<< COEF_FRAC;

    typedef struct {
        logic [1:0]           mode;
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 blk_end;
        logic [3:0]           band;
        logic [2:0]           sel;
        logic signed [CW-1:0] coef;
    } t_beat;

    typedef struct {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
        logic                 blk_end;
    } t_pair;

    typedef enum logic [1:0] {ROW_BEAT, ROW_ENABLE, ROW_LOAD_FLAT} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_beat     b;
        bit        en;
        bit        typed;
        t_pair     want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [1:0]           i_mode = sbeq_pkg::MODE_PROC;
    logic signed [SW-1:0] i_left_in = '0;
    logic signed [SW-1:0] i_right_in = '0;
    logic                 i_block_end = 1'b0;
    logic [3:0]           i_band_index = '0;
    logic [2:0]           i_coeff_select = '0;
    logic signed [CW-1:0] i_coeff_value = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic signed [SW-1:0] o_left_out;
    logic signed [SW-1:0] o_right_out;
    logic                 o_block_end_out;

    // model state
    longint coef_bank [NB][5];
    longint eq_hist [2][NB][2];
    bit     eq_on = 1'b1;

    t_pair       expected_pairs [$];
    t_pair       want_pair;
    t_row        dir_rows [$];
    int          err_count = 0;
    int unsigned cycle_count = 0;
    int          burst_left = 0;
    int          rx_style = 0;
    int          rx_left = 0;

    stereo_biquad_eq_cascade_core #(
        .NUM_BANDS_P(NB),
        .SAMPLE_BITS(SW),
        .COEFF_BITS (CW)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_left_in      (i_left_in),
        .i_right_in     (i_right_in),
        .i_block_end    (i_block_end),
        .i_band_index   (i_band_index),
        .i_coeff_select (i_coeff_select),
        .i_coeff_value  (i_coeff_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_out     (o_left_out),
        .o_right_out    (o_right_out),
        .o_block_end_out(o_block_end_out)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    function automatic longint sat_to(input longint v, input int w);
        longint hi, lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // one transposed direct form ii section, updates that channel's history
    function automatic longint biquad_section(input longint x, input int k, input int ch);
        longint acc, y, t1, t2;
        acc = coef_bank[k][sbeq_pkg::SEL_B0] * x + (eq_hist[ch][k][0] <<< HIST_SHIFT);
        y   = sat_to((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, SW);
        t1  = coef_bank[k][sbeq_pkg::SEL_B1] * x - coef_bank[k][sbeq_pkg::SEL_A1] * y
              + (eq_hist[ch][k][1] <<< HIST_SHIFT);
        t2  = coef_bank[k][sbeq_pkg::SEL_B2] * x - coef_bank[k][sbeq_pkg::SEL_A2] * y;
        eq_hist[ch][k][0] = sat_to((t1 + (longint'(1) <<< (HIST_SHIFT - 1))) >>> HIST_SHIFT, HW);
        eq_hist[ch][k][1] = sat_to((t2 + (longint'(1) <<< (HIST_SHIFT - 1))) >>> HIST_SHIFT, HW);
        return y;
    endfunction

    function automatic void predict_beat(input t_beat b, output bit has_res, output t_pair res);
        longint l, r;
        has_res     = 1'b0;
        res.left    = '0;
        res.right   = '0;
        res.blk_end = 1'b0;
        l = b.left;
        r = b.right;
        unique case (b.mode)
            sbeq_pkg::MODE_COEF: begin
                if (b.band < NB && b.sel < sbeq_pkg::NUM_COEFS)
                    coef_bank[b.band][b.sel] = longint'(b.coef);
            end
            sbeq_pkg::MODE_CLEAR: begin
                foreach (eq_hist[c, k, s]) eq_hist[c][k][s] = 0;
            end
            sbeq_pkg::MODE_PROC: begin
                if (eq_on) begin
                    for (int k = 0; k < NB; k++) begin
                        l = biquad_section(l, k, 0);
                        r = biquad_section(r, k, 1);
                    end
                end
                res.left    = l[SW-1:0];
                res.right   = r[SW-1:0];
                res.blk_end = b.blk_end;
                has_res     = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] gentle_coef(input int sel);
        longint v;
        // within +-1/8 of flat, so the cascade stays well behaved
        v = longint'($urandom_range(0, 1 << 26)) - (1 << 25);
        if (sel == sbeq_pkg::SEL_B0) v = v + UNITY_Q;
        return CW'(v);
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 4) return S_MAX;
        if (pick == 5) return S_MIN;
        if (pick == 3) return SW'(int'($urandom_range(0, 131072)) - 65536);
        return SW'($urandom);
    endfunction

    function automatic t_beat rand_beat();
        t_beat b;
        int    pick;
        pick      = $urandom_range(0, 99);
        b.mode    = (pick < 82) ? sbeq_pkg::MODE_PROC : (pick < 93) ? sbeq_pkg::MODE_COEF :
                    (pick < 97) ? sbeq_pkg::MODE_CLEAR : MODE_SPARE;
        b.left    = rand_sample();
        b.right   = rand_sample();
        b.blk_end = 1'($urandom_range(0, 1));
        b.band    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(0, NB - 1));
        b.sel     = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(0, 4));
        b.coef    = ($urandom_range(0, 3) == 0) ? CW'($urandom) : gentle_coef(int'(b.sel));
        return b;
    endfunction

    function automatic t_row beat_row(input logic [1:0] mode, input logic signed [SW-1:0] l,
                                      input logic signed [SW-1:0] r, input bit be,
                                      input int band, input logic [2:0] sel,
                                      input logic signed [CW-1:0] coef, input bit typed,
                                      input logic signed [SW-1:0] wl,
                                      input logic signed [SW-1:0] wr);
        t_row row;
        row.kind         = ROW_BEAT;
        row.b.mode       = mode;
        row.b.left       = l;
        row.b.right      = r;
        row.b.blk_end    = be;
        row.b.band       = 4'(band);
        row.b.sel        = sel;
        row.b.coef       = coef;
        row.en           = 1'b0;
        row.typed        = typed;
        row.want.left    = wl;
        row.want.right   = wr;
        row.want.blk_end = be;
        return row;
    endfunction

    function automatic t_row ctl_row(input t_row_kind kind, input bit en);
        t_row row;
        row = beat_row(sbeq_pkg::MODE_PROC, '0, '0, 1'b0, 0, '0, '0, 1'b0, '0, '0);
        row.kind = kind;
        row.en   = en;
        return row;
    endfunction

    // one beat through the input channel, with burst gaps in front
    task automatic send_beat(input t_beat b, input bit typed, input t_pair want);
        bit    has;
        t_pair got;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 8);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_mode         <= b.mode;
        i_left_in      <= b.left;
        i_right_in     <= b.right;
        i_block_end    <= b.blk_end;
        i_band_index   <= b.band;
        i_coeff_select <= b.sel;
        i_coeff_value  <= b.coef;
        do @(posedge i_clk); while (!o_ready);
        predict_beat(b, has, got);
        if (has) expected_pairs.push_back(typed ? want : got);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        // a coefficient write or clear may still be in flight
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_enable(input bit en);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= en;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        eq_on = en;
    endtask

    task automatic load_bank(input bit flat);
        t_beat b;
        t_pair none;
        none = '{default: '0};
        for (int k = 0; k < NB; k++) begin
            for (int s = 0; s < int'(sbeq_pkg::NUM_COEFS); s++) begin
                b         = rand_beat();
                b.mode    = sbeq_pkg::MODE_COEF;
                b.band    = 4'(k);
                b.sel     = 3'(s);
                b.coef    = flat ? ((s == sbeq_pkg::SEL_B0) ? CW'(UNITY_Q) : '0)
                                 : gentle_coef(s);
                send_beat(b, 1'b0, none);
            end
        end
    endtask

    task automatic run_random(input int n);
        t_beat b;
        t_pair none;
        int    done;
        none = '{default: '0};
        done = 0;
        while (done < n) begin
            b = rand_beat();
            send_beat(b, 1'b0, none);
            // ignored beats do not count
            if (b.mode == sbeq_pkg::MODE_PROC || b.mode == sbeq_pkg::MODE_CLEAR ||
                (b.mode == sbeq_pkg::MODE_COEF && b.band < NB &&
                 b.sel < sbeq_pkg::NUM_COEFS))
                done++;
        end
    endtask

    // output side: check each beat, stall on a pattern that is redrawn at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pairs.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                want_pair = expected_pairs.pop_front();
                if (o_left_out !== want_pair.left)
                    report_mismatch($sformatf("left got %0d want %0d",
                                              o_left_out, want_pair.left));
                if (o_right_out !== want_pair.right)
                    report_mismatch($sformatf("right got %0d want %0d",
                                              o_right_out, want_pair.right));
                if (o_block_end_out !== want_pair.blk_end)
                    report_mismatch($sformatf("block_end got %0b want %0b",
                                              o_block_end_out, want_pair.blk_end));
            end
        end
        if (rx_left == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_left  = $urandom_range(50, 400);
        end
        rx_left--;
        unique case (rx_style)
            0:       i_ready <= 1'b1;
            1:       i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    initial begin
        // pass-through while disabled, no coefficients needed
        dir_rows.push_back(ctl_row(ROW_ENABLE, 1'b0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MAX, S_MIN, 1'b1, 0, '0, '0, 1'b1,
                                    S_MAX, S_MIN));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MIN, S_MAX, 1'b0, 0, '0, '0, 1'b1,
                                    S_MIN, S_MAX));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, '0, SW'(-1), 1'b1, 0, '0, '0, 1'b1,
                                    '0, SW'(-1)));
        // flat bands give the input back exactly
        dir_rows.push_back(ctl_row(ROW_LOAD_FLAT, 1'b0));
        dir_rows.push_back(ctl_row(ROW_ENABLE, 1'b1));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MAX, S_MIN, 1'b0, 0, '0, '0, 1'b1,
                                    S_MAX, S_MIN));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, '0, SW'(-1), 1'b1, 0, '0, '0, 1'b1,
                                    '0, SW'(-1)));
        // gain of two in the first band, saturating at full scale
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, 0, 3'(sbeq_pkg::SEL_B0),
                                    CW'(2 * UNITY_Q), 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MAX, S_MIN, 1'b1, 0, '0, '0, 1'b1,
                                    S_MAX, S_MIN));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, SW'(4096), SW'(-4096), 1'b0, 0, '0,
                                    '0, 1'b1, SW'(8192), SW'(-8192)));
        // writes to a band past the end or a spare selector are dropped
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, 15, 3'(sbeq_pkg::SEL_B0),
                                    '0, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b1, NB, 3'(sbeq_pkg::SEL_B0),
                                    '0, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, 0, SEL_SPARE_FIRST, '0,
                                    1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b1, 0, SEL_SPARE_LAST, '0,
                                    1'b0, '0, '0));
        dir_rows.push_back(beat_row(MODE_SPARE, S_MAX, S_MIN, 1'b1, 15, SEL_SPARE_LAST, C_MIN,
                                    1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, SW'(4096), SW'(-4096), 1'b1, 0, '0,
                                    '0, 1'b1, SW'(8192), SW'(-8192)));
        // extreme feedback and nonzero feed-forward taps
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, NB - 1,
                                    3'(sbeq_pkg::SEL_A1), C_MIN, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, NB - 1,
                                    3'(sbeq_pkg::SEL_A2), C_MAX, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, 3, 3'(sbeq_pkg::SEL_B1),
                                    CW'(UNITY_Q / 2), 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_COEF, '0, '0, 1'b0, 3, 3'(sbeq_pkg::SEL_B2),
                                    CW'(-UNITY_Q / 2), 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, SW'(1000), SW'(-1000), 1'b0, 0, '0,
                                    '0, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MAX, S_MAX, 1'b1, 0, '0, '0, 1'b0,
                                    '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, S_MIN, S_MIN, 1'b0, 0, '0, '0, 1'b0,
                                    '0, '0));
        // silence after a clear stays silent
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_CLEAR, S_MIN, S_MAX, 1'b1, 15,
                                    SEL_SPARE_LAST, C_MAX, 1'b0, '0, '0));
        dir_rows.push_back(beat_row(sbeq_pkg::MODE_PROC, '0, '0, 1'b1, 0, '0, '0, 1'b1,
                                    '0, '0));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            unique case (dir_rows[i].kind)
                ROW_BEAT:   send_beat(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
                ROW_ENABLE: set_enable(dir_rows[i].en);
                default:    load_bank(1'b1);
            endcase
        end

        load_bank(1'b0);
        set_enable(1'b1);
        run_random(230);
        set_enable(1'b0);
        run_random(90);
        set_enable(1'b1);
        load_bank(1'b0);
        run_random(120);
        // hold the sender until the output side has drained
        wait_idle();
        run_random(130);
        wait_idle();

        if (expected_pairs.size() != 0)
            report_mismatch("expected beats left over");
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
